// File: sv/tws_pkg.sv
// Shared types and constants for the trie word store.
`timescale 1ns / 1ps

package tws_pkg;

    // Default sizing
    localparam int NODE_COUNT    = 1024;
    localparam int ALPHABET_SIZE = 26;

    // Operation codes; any code with the high bit set is a prefix search
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_EXACT  = 2'd1;
    localparam logic [1:0] OP_PREFIX = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] letter;
        logic       last_letter;
    } req_t;

    typedef struct packed {
        logic found;
        logic status;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic exec;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic last_letter;
        logic out_blocked;
    } ctl_sts_t;

endpackage

// File: sv/tws_ctrl.sv
// Sequencing controller for the trie word store: clear pass, accept, execute.
`timescale 1ns / 1ps

module tws_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  tws_pkg::ctl_sts_t sts,
    output tws_pkg::ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   exec_ok;

    assign exec_ok   = !(sts.last_letter && sts.out_blocked);
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // a final letter waits until the result register is free
                if (exec_ok)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_clear_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !req_ready)
        else $error("request taken during clear pass");

    a_exec_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == S_EXEC)
        else $error("accepted request not executed");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear_step, cmd.accept, cmd.exec}))
        else $error("conflicting datapath commands");

endmodule

// File: sv/tws_datapath.sv
// Datapath for the trie word store: child link memory, walk registers, result register.
`timescale 1ns / 1ps

module tws_datapath
#(
    parameter int NODE_COUNT    = tws_pkg::NODE_COUNT,
    parameter int ALPHABET_SIZE = tws_pkg::ALPHABET_SIZE
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tws_pkg::req_t     req,
    output tws_pkg::rsp_t     rsp,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  tws_pkg::ctl_cmd_t cmd,
    output tws_pkg::ctl_sts_t sts
);

    localparam int NW        = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int DEPTH     = NODE_COUNT * ALPHABET_SIZE;
    localparam int AW        = $clog2(DEPTH);
    localparam int LAST_ADDR = DEPTH - 1;

    // Each slot holds {end mark of the child, child link}. A node has one
    // parent slot, so its word-end mark lives there (the root is never a
    // word end since words are at least one letter).
    logic [NW:0]   child_mem [DEPTH];

    logic [AW-1:0] clr_cnt_reg;
    logic [NW-1:0] cursor_reg;
    logic [NW-1:0] cursor_next;
    logic          lost_reg;
    logic          lost_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic [NW:0]   next_free_reg;
    logic [NW:0]   next_free_next;

    logic [1:0]    op_reg;
    logic          last_reg;
    logic          range_ok_reg;
    logic [AW-1:0] addr_reg;
    logic [NW:0]   rd_data_reg;

    logic          range_ok;
    logic [AW-1:0] rd_addr;

    logic          is_insert;
    logic          is_exact;
    logic [NW-1:0] child;
    logic          child_end;
    logic          alloc;
    logic          mark;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [NW:0]   wr_data;

    tws_pkg::rsp_t rsp_reg;
    tws_pkg::rsp_t rsp_next;
    logic          rsp_valid_reg;

    assign range_ok = int'(req.letter) < ALPHABET_SIZE;
    assign rd_addr  = range_ok ?
        (AW'(cursor_reg) * AW'(ALPHABET_SIZE) + AW'(req.letter)) : '0;

    assign is_insert = (op_reg == tws_pkg::OP_INSERT);
    assign is_exact  = (op_reg == tws_pkg::OP_EXACT);
    assign child     = rd_data_reg[NW-1:0];
    assign child_end = rd_data_reg[NW];

    // One letter of the walk
    always_comb
    begin
        cursor_next    = cursor_reg;
        lost_next      = lost_reg;
        ovf_next       = ovf_reg;
        next_free_next = next_free_reg;
        alloc          = 1'b0;
        if (!lost_reg)
        begin
            if (!range_ok_reg)
            begin
                lost_next = 1'b1;
            end
            else if (child != '0)
            begin
                cursor_next = child;
            end
            else if (!is_insert)
            begin
                lost_next = 1'b1;
            end
            else if (next_free_reg == (NW+1)'(NODE_COUNT))
            begin
                ovf_next  = 1'b1;
                lost_next = 1'b1;
            end
            else
            begin
                alloc          = 1'b1;
                cursor_next    = next_free_reg[NW-1:0];
                next_free_next = next_free_reg + (NW+1)'(1);
            end
        end
        mark = last_reg && is_insert && !lost_next;

        rsp_next = '0;
        if (is_insert)
        begin
            rsp_next.status = ovf_next;
        end
        else if (is_exact)
        begin
            rsp_next.found = !lost_next && child_end;
        end
        else
        begin
            rsp_next.found = !lost_next;
        end
    end

    // Memory write port: clear pass, new link, or end mark on an existing link
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = {mark, cursor_next};
        if (cmd.clear_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else if (cmd.exec)
        begin
            wr_en = alloc || mark;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            child_mem[wr_addr] <= wr_data;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= child_mem[rd_addr];
        end
    end

    // Request capture and result register (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= req.opcode;
            last_reg     <= req.last_letter;
            range_ok_reg <= range_ok;
            addr_reg     <= rd_addr;
        end
        if (cmd.exec && last_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            cursor_reg    <= '0;
            lost_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            next_free_reg <= (NW+1)'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.exec)
            begin
                next_free_reg <= next_free_next;
                if (last_reg)
                begin
                    cursor_reg <= '0;
                    lost_reg   <= 1'b0;
                    ovf_reg    <= 1'b0;
                end
                else
                begin
                    cursor_reg <= cursor_next;
                    lost_reg   <= lost_next;
                    ovf_reg    <= ovf_next;
                end
            end
            if (cmd.exec && last_reg)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    assign sts.clear_last  = (clr_cnt_reg == AW'(LAST_ADDR));
    assign sts.last_letter = last_reg;
    assign sts.out_blocked = rsp_valid_reg && !rsp_ready;

    a_alloc_insert_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && alloc |-> is_insert && !lost_reg)
        else $error("node allocated outside an insert walk");

    a_word_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && last_reg |=> cursor_reg == '0 && !lost_reg && !ovf_reg)
        else $error("walk state not returned to root after word");

    a_ovf_implies_lost: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> lost_reg)
        else $error("pool overflow without lost path");

    a_pool_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> next_free_reg >= $past(next_free_reg)
            && next_free_reg <= (NW+1)'(NODE_COUNT))
        else $error("free node index moved backward or past pool");

endmodule

// File: sv/trie_word_store_unit.sv
// Top level of the trie word store: controller plus datapath.
`timescale 1ns / 1ps

// Channel   Dir  Handshake             Payload
// req       in   req_valid/req_ready   tws_pkg::req_t {opcode, letter, last_letter}
// rsp       out  rsp_valid/rsp_ready   tws_pkg::rsp_t {found, status}
//
// Each letter request first reads the child link of the current node
// from the link memory (registered read), then updates it.
// A result appears only on a word's last letter, in the cycle after that
// letter's update; a final letter waits in its update cycle while a
// previous result has not been taken by the consumer.
// After reset a clearing pass writes every link slot to null, one slot a
// cycle, NODE_COUNT*ALPHABET_SIZE slots (26624 at the defaults); no
// request is taken until it finishes.

module trie_word_store_unit
#(
    parameter int NODE_COUNT    = tws_pkg::NODE_COUNT,
    parameter int ALPHABET_SIZE = tws_pkg::ALPHABET_SIZE
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  tws_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output tws_pkg::rsp_t rsp
);

    tws_pkg::ctl_cmd_t cmd;
    tws_pkg::ctl_sts_t sts;

    // Sequencer: clear pass, then alternating accept and update cycles
    tws_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Link memory, walk state (cursor, lost path, overflow, free pointer)
    // and the result register
    tws_datapath
    #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
